// File: rtl/column_norm_rescale_defines.svh
// Assertion macros for the column norm rescale block.
// Used by the top level only; define ASSERT_OFF to drop all checks.
`ifndef COLUMN_NORM_RESCALE_DEFINES_SVH
`define COLUMN_NORM_RESCALE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CNR_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define CNR_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define CNR_ASSERT_IMP(lbl, a, b)
`define CNR_ASSERT_NXT(lbl, a, b)
`endif
`endif

// File: rtl/cnr_pkg.sv
// Shared types and constants of the column norm rescale block.
// No dependencies.
`timescale 1ns / 1ps
package cnr_pkg;
  localparam int MaxRows    = 32;
  localparam int WeightBits = 16;
  localparam int RowBits    = 5;
  localparam int RegBits    = 22;
  localparam int AccBits    = 36;
  localparam int NumBits    = 40;
  localparam int DenBits    = 24;
  localparam int RemBits    = 26;
  localparam int IdxBits    = 4;
  localparam logic [RegBits-1:0] NormMax = 22'h3FFFFF;

  localparam logic [IdxBits-1:0] RegNormMode   = 4'd0;
  localparam logic [IdxBits-1:0] RegMinNorm    = 4'd1;
  localparam logic [IdxBits-1:0] RegMaxNorm    = 4'd2;
  localparam logic [IdxBits-1:0] RegTargetNorm = 4'd3;

  localparam logic [1:0] ModeL1    = 2'd1;
  localparam logic [1:0] ModeL1Pos = 2'd2;

  typedef struct packed {
    logic start;
    logic op_sqrt;
  } cnr_iter_req_t;
endpackage

// File: rtl/cnr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cnr_iter.sv
// Shared shift/compare/subtract unit: integer square root, two bits a cycle,
// or restoring division, one bit a cycle. Depends on cnr_pkg.
`timescale 1ns / 1ps
module cnr_iter (
  input  logic                           clk,
  input  logic                           rst,
  input  cnr_pkg::cnr_iter_req_t         req,
  input  logic [cnr_pkg::NumBits-1:0]    num,
  input  logic [cnr_pkg::DenBits-1:0]    den,
  output logic                           done,
  output logic [cnr_pkg::NumBits-1:0]    result
);
  import cnr_pkg::*;

  logic               busy;
  logic               op_sqrt;
  logic [5:0]         cnt;
  logic [NumBits-1:0] src;
  logic [RemBits-1:0] rem;
  logic [DenBits-1:0] dreg;
  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] trial;
  logic               fits;

  always_comb begin
    if (op_sqrt) begin
      rem_sh = {rem[RemBits-3:0], src[NumBits-1 -: 2]};
      trial  = {4'b0, result[19:0], 2'b01};
    end else begin
      rem_sh = {rem[RemBits-2:0], src[NumBits-1]};
      trial  = {2'b0, dreg};
    end
    fits = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        op_sqrt <= req.op_sqrt;
        cnt     <= req.op_sqrt ? 6'd20 : 6'd40;
        src     <= num;
        dreg    <= den;
        rem     <= '0;
        result  <= '0;
      end else if (busy) begin
        src    <= op_sqrt ? {src[NumBits-3:0], 2'b00} : {src[NumBits-2:0], 1'b0};
        rem    <= fits ? rem_sh - trial : rem_sh;
        result <= {result[NumBits-2:0], fits};
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/column_norm_rescale.sv
// Top level of the column norm rescale block: sequencer, buffer, multiplier.
// Depends on cnr_pkg, cnr_ram, cnr_iter and column_norm_rescale_defines.svh.
//
//  channel  signals                                     dir
//  input    in_valid in_ready weight_in column_end      in
//  output   out_valid out_ready weight_out last_out     out
//           was_rescaled saturated
//  config   cfg_we cfg_index cfg_data                   in
//
// An element that does not close the column is only written to the buffer.
// A closing column is summed element by element (S_SUM_RD, S_SUM_ADD), goes
// through the root (L2 only, S_SQRT) and one check (S_CHK), then each element
// passes S_RD, S_MUL, S_OUT, and S_DIVGO, S_DIV in the divider if rescaled.
// Reset is synchronous; the buffer needs no clearing. Input is held off until
// the last element of the column is taken; a stalled output holds the block.
`timescale 1ns / 1ps
`include "column_norm_rescale_defines.svh"
module column_norm_rescale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cnr_pkg::WeightBits-1:0] weight_in,
  input  logic                               column_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cnr_pkg::WeightBits-1:0] weight_out,
  output logic                               last_out,
  output logic                               was_rescaled,
  output logic                               saturated,
  input  logic                               cfg_we,
  input  logic [cnr_pkg::IdxBits-1:0]        cfg_index,
  input  logic [cnr_pkg::RegBits-1:0]        cfg_data
);
  import cnr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SUM_RD  = 10'b0000000010,
    S_SUM_ADD = 10'b0000000100,
    S_SQRT    = 10'b0000001000,
    S_CHK     = 10'b0000010000,
    S_RD      = 10'b0000100000,
    S_MUL     = 10'b0001000000,
    S_DIVGO   = 10'b0010000000,
    S_DIV     = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t state;
  logic [1:0]         norm_mode, mode_q;
  logic [RegBits-1:0] norm_lo, norm_hi, norm_goal;
  logic [5:0]         cnt;
  logic [RowBits-1:0] n_last, idx;
  logic [AccBits-1:0] acc;
  logic               rescale;
  logic [RegBits:0]   div_q;
  logic signed [WeightBits-1:0] v_q;
  logic [37:0]        p_q;

  logic signed [WeightBits-1:0] rd, vz;
  logic [WeightBits-1:0] mag;
  logic [RegBits-1:0] mul_b;
  logic [37:0]        prod;
  logic               l1, in_beat, close, last_idx;
  cnr_iter_req_t      req;
  logic [NumBits-1:0] num, q;
  logic [DenBits-1:0] den;
  logic               done;
  logic [AccBits-1:0] norm_src;
  logic [RegBits-1:0] norm;
  logic [WeightBits-1:0] lim, q_c;
  logic               q_sat;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign in_beat   = in_valid && in_ready;
  assign close     = column_end || (cnt == 6'(MaxRows - 1));
  assign l1        = (mode_q == ModeL1) || (mode_q == ModeL1Pos);
  assign last_idx  = idx == n_last;

  cnr_ram #(.WIDTH(WeightBits), .DEPTH(MaxRows)) u_buf (
    .clk(clk), .we(in_beat), .waddr(cnt[RowBits-1:0]), .wdata(weight_in),
    .raddr(idx), .rdata(rd)
  );

  // zero negatives in mode 2, then take the magnitude
  always_comb begin
    vz    = ((mode_q == ModeL1Pos) && rd[WeightBits-1]) ? '0 : rd;
    mag   = vz[WeightBits-1] ? WeightBits'(~vz + 1'b1) : vz;
    mul_b = (state == S_SUM_ADD) ? RegBits'(mag) : norm_goal;
    prod  = 38'(mag) * 38'(mul_b);
  end

  assign req.start   = ((state == S_SUM_ADD) && last_idx && !l1) || (state == S_DIVGO);
  assign req.op_sqrt = state == S_SUM_ADD;
  assign num = state == S_SUM_ADD ? NumBits'(acc + (l1 ? AccBits'(mag) : AccBits'(prod)))
                                  : NumBits'({p_q, 1'b0}) + NumBits'(div_q);
  assign den = {div_q, 1'b0};

  cnr_iter u_iter (
    .clk(clk), .rst(rst), .req(req), .num(num), .den(den), .done(done), .result(q)
  );

  always_comb begin
    norm_src = l1 ? acc : AccBits'(q);
    norm     = (norm_src > AccBits'(NormMax)) ? NormMax : norm_src[RegBits-1:0];
    lim      = v_q[WeightBits-1] ? WeightBits'(1 << (WeightBits - 1))
                                 : WeightBits'((1 << (WeightBits - 1)) - 1);
    q_sat    = q > NumBits'(lim);
    q_c      = q_sat ? lim : q[WeightBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode <= '0;
      norm_lo   <= '0;
      norm_hi   <= NormMax;
      norm_goal <= RegBits'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegNormMode:   norm_mode <= cfg_data[1:0];
        RegMinNorm:    norm_lo   <= cfg_data;
        RegMaxNorm:    norm_hi   <= cfg_data;
        RegTargetNorm: norm_goal <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
      acc   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            cnt <= cnt + 6'd1;
            if (close) begin
              n_last <= cnt[RowBits-1:0];
              mode_q <= norm_mode;
              idx    <= '0;
              acc    <= '0;
              state  <= S_SUM_RD;
            end
          end
        end
        S_SUM_RD: state <= S_SUM_ADD;
        S_SUM_ADD: begin
          acc <= acc + (l1 ? AccBits'(mag) : AccBits'(prod));
          if (last_idx) begin
            state <= l1 ? S_CHK : S_SQRT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SUM_RD;
          end
        end
        S_SQRT: if (done) state <= S_CHK;
        S_CHK: begin
          rescale <= (norm > norm_hi) || (norm < norm_lo);
          div_q   <= {1'b0, norm} + 1'b1;
          idx     <= '0;
          state   <= S_RD;
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          p_q      <= prod;
          v_q      <= vz;
          last_out <= last_idx;
          if (rescale) begin
            state <= S_DIVGO;
          end else begin
            weight_out   <= vz;
            was_rescaled <= 1'b0;
            saturated    <= 1'b0;
            state        <= S_OUT;
          end
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (done) begin
            weight_out   <= v_q[WeightBits-1] ? WeightBits'(-q_c) : q_c;
            was_rescaled <= 1'b1;
            saturated    <= q_sat;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (last_idx) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CNR_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `CNR_ASSERT_NXT(a_last_frees, out_valid && out_ready && last_out, in_ready)
  `CNR_ASSERT_IMP(a_sat_only_scaled, out_valid && saturated, was_rescaled)
endmodule

// File: sim/testbench.sv
// Self-checking testbench for column_norm_rescale: directed table, then random columns.
// Depends on cnr_pkg and the column_norm_rescale RTL; results checked by an in-file predictor.
`timescale 1ns / 1ps
module testbench;
  import cnr_pkg::*;

  localparam logic [1:0] ModeL2 = 2'd0;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam logic [IdxBits-1:0] RegSpare = 4'd9;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 100;

  typedef struct {
    logic signed [WeightBits-1:0] w;
    bit last;
    bit resc;
    bit sat;
  } beat_t;

  typedef struct {
    logic signed [WeightBits-1:0] w;
    bit eoc;
    bit known;
    logic signed [WeightBits-1:0] kw;
  } row_t;

  typedef struct {
    logic [1:0] mode;
    logic [RegBits-1:0] lo;
    logic [RegBits-1:0] hi;
    logic [RegBits-1:0] tgt;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WeightBits-1:0] weight_in = '0;
  logic column_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WeightBits-1:0] weight_out;
  logic last_out, was_rescaled, saturated;
  logic cfg_we = 1'b0;
  logic [IdxBits-1:0] cfg_index = '0;
  logic [RegBits-1:0] cfg_data = '0;

  // predictor copy of registers and column
  logic [1:0] p_mode = ModeL2;
  logic [RegBits-1:0] p_min = '0;
  logic [RegBits-1:0] p_max = NormMax;
  logic [RegBits-1:0] p_tgt = 22'd4096;
  logic signed [WeightBits-1:0] col_buf [MaxRows];
  int col_fill = 0;
  beat_t expected_beats [$];

  int errors = 0;
  int beats_checked = 0;
  int columns_closed = 0;
  int rescaled_cols = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  column_norm_rescale u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts until the quiet tail
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat weight_out=%0d", weight_out);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        beats_checked++;
        if (weight_out !== e.w) begin
          $error("weight_out expected %0d got %0d", e.w, weight_out);
          errors++;
        end
        if (last_out !== e.last) begin
          $error("last_out expected %0b got %0b", e.last, last_out);
          errors++;
        end
        if (was_rescaled !== e.resc) begin
          $error("was_rescaled expected %0b got %0b", e.resc, was_rescaled);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0b got %0b", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // buffer one element; on column close, queue the expected output column
  function automatic void predict_column(logic signed [WeightBits-1:0] w, bit eoc);
    longint unsigned acc, m, t, norm, dv, p, q, lim;
    longint v;
    bit l1, resc, neg;
    beat_t b;
    col_buf[col_fill] = w;
    col_fill++;
    if (col_fill >= MaxRows) eoc = 1'b1;
    if (!eoc) return;
    l1 = (p_mode == ModeL1) || (p_mode == ModeL1Pos);
    if (p_mode == ModeL1Pos)
      for (int i = 0; i < col_fill; i++)
        if (col_buf[i] < 0) col_buf[i] = '0;
    acc = 0;
    for (int i = 0; i < col_fill; i++) begin
      v = col_buf[i];
      m = (v < 0) ? -v : v;
      t = l1 ? m : m * m;
      if (acc > (64'd1 << 62) - t) acc = 64'd1 << 62;
      else acc = acc + t;
    end
    norm = l1 ? acc : int_sqrt(acc);
    if (norm > NormMax) norm = NormMax;
    resc = (norm > p_max) || (norm < p_min);
    dv = norm + 1;
    for (int i = 0; i < col_fill; i++) begin
      v = col_buf[i];
      b.w = col_buf[i];
      b.sat = 1'b0;
      if (resc) begin
        neg = v < 0;
        m = neg ? -v : v;
        p = m * p_tgt;
        q = (2 * p + dv) / (2 * dv);
        lim = neg ? 32768 : 32767;
        if (q > lim) begin
          q = lim;
          b.sat = 1'b1;
        end
        b.w = WeightBits'(neg ? -q : q);
      end
      b.last = (i + 1 == col_fill);
      b.resc = resc;
      expected_beats.push_back(b);
    end
    columns_closed++;
    if (resc) rescaled_cols++;
    col_fill = 0;
  endfunction

  task automatic send_beat(logic signed [WeightBits-1:0] w, bit eoc, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    weight_in <= w;
    column_end <= eoc;
    do @(posedge clk); while (!in_ready);
    predict_column(w, eoc);
  endtask

  task automatic write_reg(logic [IdxBits-1:0] idx, logic [RegBits-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegNormMode:   p_mode = val[1:0];
      RegMinNorm:    p_min = val;
      RegMaxNorm:    p_max = val;
      RegTargetNorm: p_tgt = val;
      default: ;
    endcase
  endtask

  // hold the sender until every result is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [WeightBits-1:0] pick_weight();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return '0;
      2: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  row_t directed [] = '{
    '{16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF},
    '{16'sh8000, 1'b1, 1'b1, 16'sh8000},
    '{16'sh0000, 1'b1, 1'b1, 16'sh0000},
    '{16'sh0001, 1'b1, 1'b1, 16'sh0001},
    '{16'shFFFF, 1'b1, 1'b1, 16'shFFFF},
    '{16'sh1000, 1'b0, 1'b0, 16'sh0000},
    '{16'shF000, 1'b1, 1'b0, 16'sh0000},
    '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
    '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b1, 1'b0, 16'sh0000},
    '{16'sh5555, 1'b0, 1'b0, 16'sh0000},
    '{16'shAAAA, 1'b1, 1'b0, 16'sh0000}
  };

  setting_t settings [] = '{
    '{ModeL2,    22'd0,    NormMax,    22'd4096},
    '{ModeL2,    22'd0,    22'd4096,   22'd4096},
    '{ModeL1,    22'd0,    22'd0,      NormMax},
    '{ModeL1Pos, 22'd8192, 22'd20000,  22'd4096},
    '{ModeSpare, NormMax,  NormMax,    22'd0},
    '{ModeL2,    22'd20000, 22'd100,   22'd12345},
    '{ModeL1Pos, 22'd0,    22'd3000,   22'd40000},
    '{ModeL1,    22'd0,    NormMax,    22'd4096}
  };

  initial begin
    int left, len;
    setting_t s;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_beat(directed[i].w, directed[i].eoc, 1'b1);
      if (directed[i].known) expected_beats[expected_beats.size() - 1].w = directed[i].kw;
    end
    // full buffer with no end flag closes on the last slot
    for (int i = 0; i < MaxRows; i++) send_beat(pick_weight(), 1'b0, 1'b1);

    foreach (settings[ph]) begin
      drain();
      s = settings[ph];
      if (ph == 6) begin
        s.mode = 2'($urandom_range(0, 3));
        s.lo = RegBits'($urandom_range(0, 30000));
        s.hi = RegBits'($urandom_range(0, 60000));
        s.tgt = 22'($urandom);
      end
      write_reg(RegNormMode, RegBits'(s.mode));
      write_reg(RegMinNorm, s.lo);
      write_reg(RegMaxNorm, s.hi);
      write_reg(RegTargetNorm, s.tgt);
      if (ph == 0) write_reg(RegSpare, 22'd7);
      cfg_we <= 1'b0;
      if (ph == settings.size() - 1) quiet = 1'b1;
      left = 35;
      while (left > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxRows, MaxRows + 4)
                                          : $urandom_range(1, 8);
        // columns longer than MaxRows carry no end flag and close on the full buffer
        for (int k = 0; k < len; k++)
          send_beat(pick_weight(), (len <= MaxRows) && (k == len - 1), 1'b1);
        left -= len;
      end
      if (col_fill != 0) send_beat(pick_weight(), 1'b1, 1'b1);
    end

    drain();
    $display("Checked %0d output beats in %0d columns, %0d of them rescaled,",
             beats_checked, columns_closed, rescaled_cols);
    $display("across %0d register settings and all four norm modes.", settings.size() + 1);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/cnr_pkg.sv
rtl/cnr_ram.sv
rtl/cnr_iter.sv
rtl/column_norm_rescale.sv
sim/testbench.sv
